>>> design/lsg_pkg.sv
// Shared constants, types and fixed-point helpers for the Gaussian elimination solver.
`default_nettype none

package lsg_pkg;

	// Field and port widths
	localparam int DATA_W      = 64;
	localparam int THR_W       = 41;
	localparam int SIZE_W      = 5;
	localparam int FIELD_W     = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int CMD_W       = 2;

	// Commands carried in the input tuser
	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

	// Register reset values
	localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;
	localparam logic [THR_W-1:0]  THR_RST  = 41'd110;

	// Saturation limits
	localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_PIV_RD,
		S_PIV_CHK,
		S_PIV_TEST,
		S_DIV_RD,
		S_DIV_GO,
		S_DIV_WR,
		S_ELF_RD,
		S_ELF_GET,
		S_EL_RD,
		S_EL_GO,
		S_EL_TRD,
		S_EL_WR,
		S_BK_RD,
		S_BK_CHK,
		S_BK_XRD,
		S_BK_XGET,
		S_BK_EMIT,
		S_BK_F_RD,
		S_BK_F_GO,
		S_BK_B_RD,
		S_BK_WR,
		S_ERR,
		S_ARITH
	} state_t;

	// Magnitude of a two's complement value; the most negative value maps to 2^63
	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 64'd1) : v;
	endfunction

	// Saturating signed subtract a - b
	function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
	                                              input logic [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1])
			return d[DATA_W] ? VAL_MIN : VAL_MAX;
		return d[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/lsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 272
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/linear_system_solver_gauss.sv
// Top level of the fixed-point Gaussian elimination solver with partial pivoting.
`default_nettype none

// Solves A*x = b in signed Q23.40 (FRACTION_BITS fraction bits). Load items
// (tuser = load A / load b) write one entry each and are taken one per cycle
// while idle. A solve item holds s_axis_tready low until the solve is finished.
// Row scaling uses the bit-serial divider, which makes one quotient bit a
// cycle; each elimination update costs a multiply built from 32x32 partial
// products, two reads on the single shared read port and one RAM write.
// Results come out last row first, n of them, or a single result with tuser
// (singular) set when a pivot is below threshold.
// Matrix and right-hand side share one RAM; a solve overwrites them in place.
module linear_system_solver_gauss #(
	parameter int MAX_SIZE      = 16,
	parameter int FRACTION_BITS = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lsg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row[3:0], col[7:4], value[71:8]
	input  logic [lsg_pkg::CMD_W-1:0]         s_axis_tuser,  // command[1:0]
	// Result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [lsg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // index[3:0], solution[67:4], zero pad
	output logic                              m_axis_tlast,
	output logic [0:0]                        m_axis_tuser,  // singular[0]
	// Configuration writes
	input  logic                              cfg_we,
	input  logic [lsg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsg_pkg::THR_W-1:0]         cfg_data
);

	import lsg_pkg::*;

	localparam int IW    = $clog2(MAX_SIZE + 1);
	localparam int COLS  = MAX_SIZE + 1;
	localparam int DEPTH = MAX_SIZE * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [IW-1:0]     RHS_COL = IW'(MAX_SIZE);
	localparam logic [DATA_W-1:0] ONE     = 64'(1) << FRACTION_BITS;

	// Address of entry (r, c); column MAX_SIZE holds the right-hand side
	function automatic logic [AW-1:0] cell_addr(input int unsigned r, input int unsigned c);
		return AW'(r * COLS + c);
	endfunction

	// Input fields
	logic [CMD_W-1:0]   in_cmd;
	logic [FIELD_W-1:0] in_row;
	logic [FIELD_W-1:0] in_col;
	logic [DATA_W-1:0]  in_value;

	assign in_cmd   = s_axis_tuser;
	assign in_row   = s_axis_tdata[3:0];
	assign in_col   = s_axis_tdata[7:4];
	assign in_value = s_axis_tdata[71:8];

	// Configuration registers
	logic [SIZE_W-1:0] size_q;
	logic [THR_W-1:0]  thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
			thr_q  <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE:   size_q <= cfg_data[SIZE_W-1:0];
				REG_THRESH: thr_q  <= cfg_data;
			endcase
		end
	end

	// Sequencer registers
	state_t            state_q, state_d, ret_q, ret_d;
	logic [IW-1:0]     n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, m_q, m_d;
	logic [DATA_W-1:0] best_q, best_d, p_q, p_d, f_q, f_d, t_q, t_d;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	lsg_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared multiply / divide unit
	logic                  mul_go, div_go, op_div_q, neg_q, arith_done;
	logic [DATA_W-1:0]     op_a, op_b, mx_q, my_q, rem_q;
	logic [2*DATA_W-1:0]   acc_q, num_q, res_mag, pp_w;
	logic [6:0]            step_q;
	logic [31:0]           x_half, y_half;
	logic [DATA_W:0]       rem2;
	logic                  rem_ge;
	logic [DATA_W-1:0]     arith_res;

	assign x_half     = step_q[1] ? mx_q[63:32] : mx_q[31:0];
	assign y_half     = step_q[0] ? my_q[63:32] : my_q[31:0];
	assign pp_w       = {64'b0, 64'(x_half) * 64'(y_half)} << (32 * (step_q[1] + step_q[0]));
	assign rem2       = {rem_q, num_q[2*DATA_W-1]};
	assign rem_ge     = rem2 >= {1'b0, my_q};
	assign arith_done = op_div_q ? (step_q == 7'd127) : (step_q == 7'd3);

	// Result of the unit: shift product down, saturate to the signed range
	assign res_mag   = op_div_q ? acc_q : (acc_q >> FRACTION_BITS);
	assign arith_res = (|res_mag[2*DATA_W-1:DATA_W-1]) ? (neg_q ? VAL_MIN : VAL_MAX)
	                 : (neg_q ? (~res_mag[DATA_W-1:0] + 64'd1) : res_mag[DATA_W-1:0]);

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mx_q     <= mag(op_a);
			my_q     <= mag(op_b);
			neg_q    <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
			acc_q    <= '0;
			step_q   <= '0;
			op_div_q <= 1'b0;
		end else if (div_go) begin
			num_q    <= {64'b0, mag(op_a)} << FRACTION_BITS;
			my_q     <= mag(op_b);
			rem_q    <= '0;
			neg_q    <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
			step_q   <= '0;
			op_div_q <= 1'b1;
			// zero divisor: saturate unless the dividend is zero too
			acc_q    <= (op_b == '0 && op_a != '0) ? '1 : '0;
		end else if (state_q == S_ARITH) begin
			step_q <= step_q + 7'd1;
			if (op_div_q) begin
				rem_q <= rem_ge ? rem2[DATA_W-1:0] - my_q : rem2[DATA_W-1:0];
				num_q <= num_q << 1;
				acc_q <= {acc_q[2*DATA_W-2:0], rem_ge};
			end else begin
				acc_q <= acc_q + pp_w;
			end
		end
	end

	// Output register
	logic                 out_valid_q, out_last_q, out_sing_q, out_free;
	logic                 emit_bk, emit_err;
	logic [FIELD_W-1:0]   out_index_q;
	logic [DATA_W-1:0]    out_sol_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_sol_q, out_index_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_bk || emit_err)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_bk) begin
			out_index_q <= FIELD_W'(m_q);
			out_sol_q   <= t_q;
			out_last_q  <= (i_q == '0);
			out_sing_q  <= 1'b0;
		end else if (emit_err) begin
			out_index_q <= '0;
			out_sol_q   <= '0;
			out_last_q  <= 1'b1;
			out_sing_q  <= 1'b1;
		end
	end

	// Clamped system size taken at solve start
	logic [IW-1:0] n_start, j_next;

	assign n_start = (size_q == '0) ? IW'(1)
	               : (32'(size_q) > MAX_SIZE) ? IW'(MAX_SIZE) : IW'(size_q);
	assign j_next  = (j_q == n_q - 1'b1) ? RHS_COL : IW'(j_q + 1'b1);

	// Sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			m_q     <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			n_q     <= n_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			m_q     <= m_d;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		p_q    <= p_d;
		f_q    <= f_d;
		t_q    <= t_d;
	end

	// Next state, RAM control and unit control
	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		n_d           = n_q;
		i_d           = i_q;
		j_d           = j_q;
		k_d           = k_q;
		m_d           = m_q;
		best_d        = best_q;
		p_d           = p_q;
		f_d           = f_q;
		t_d           = t_q;
		ram_we        = 1'b0;
		ram_waddr     = '0;
		ram_wdata     = '0;
		ram_raddr     = '0;
		mul_go        = 1'b0;
		div_go        = 1'b0;
		op_a          = ram_rdata;
		op_b          = p_q;
		emit_bk       = 1'b0;
		emit_err      = 1'b0;
		s_axis_tready = (state_q == S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					case (in_cmd)
						CMD_LOAD_A: begin
							if (32'(in_row) < MAX_SIZE && 32'(in_col) < MAX_SIZE) begin
								ram_we    = 1'b1;
								ram_waddr = cell_addr(in_row, in_col);
								ram_wdata = in_value;
							end
						end
						CMD_LOAD_B: begin
							if (32'(in_row) < MAX_SIZE) begin
								ram_we    = 1'b1;
								ram_waddr = cell_addr(in_row, MAX_SIZE);
								ram_wdata = in_value;
							end
						end
						CMD_SOLVE: begin
							n_d     = n_start;
							i_d     = '0;
							j_d     = '0;
							m_d     = '0;
							best_d  = '0;
							p_d     = '0;
							state_d = S_PIV_RD;
						end
						default: ;
					endcase
				end
			end

			// Pivot search over row i
			S_PIV_RD: begin
				ram_raddr = cell_addr(i_q, j_q);
				state_d   = S_PIV_CHK;
			end
			S_PIV_CHK: begin
				if (mag(ram_rdata) > best_q) begin
					best_d = mag(ram_rdata);
					m_d    = j_q;
					p_d    = ram_rdata;
				end
				if (j_q == n_q - 1'b1) begin
					state_d = S_PIV_TEST;
				end else begin
					j_d     = IW'(j_q + 1'b1);
					state_d = S_PIV_RD;
				end
			end
			S_PIV_TEST: begin
				if (best_q < 64'(thr_q)) begin
					state_d = S_ERR;
				end else begin
					j_d     = '0;
					state_d = S_DIV_RD;
				end
			end

			// Scale row i (and its rhs) by the pivot; pivot column becomes one
			S_DIV_RD: begin
				if (j_q == m_q) begin
					ram_we    = 1'b1;
					ram_waddr = cell_addr(i_q, j_q);
					ram_wdata = ONE;
					j_d       = j_next;
				end else begin
					ram_raddr = cell_addr(i_q, j_q);
					state_d   = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				div_go  = 1'b1;
				ret_d   = S_DIV_WR;
				state_d = (p_q == '0) ? S_DIV_WR : S_ARITH;
			end
			S_DIV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(i_q, j_q);
				ram_wdata = arith_res;
				if (j_q == RHS_COL) begin
					if (IW'(i_q + 1'b1) == n_q) begin
						j_d     = '0;
						m_d     = '0;
						state_d = S_BK_RD;
					end else begin
						k_d     = IW'(i_q + 1'b1);
						state_d = S_ELF_RD;
					end
				end else begin
					j_d     = j_next;
					state_d = S_DIV_RD;
				end
			end

			// Eliminate the pivot column from row k
			S_ELF_RD: begin
				ram_raddr = cell_addr(k_q, m_q);
				state_d   = S_ELF_GET;
			end
			S_ELF_GET: begin
				f_d     = ram_rdata;
				j_d     = '0;
				state_d = S_EL_RD;
			end
			S_EL_RD: begin
				if (j_q == m_q) begin
					ram_we    = 1'b1;
					ram_waddr = cell_addr(k_q, j_q);
					ram_wdata = '0;
					j_d       = j_next;
				end else begin
					ram_raddr = cell_addr(i_q, j_q);
					state_d   = S_EL_GO;
				end
			end
			S_EL_GO: begin
				mul_go  = 1'b1;
				op_a    = f_q;
				op_b    = ram_rdata;
				ret_d   = S_EL_TRD;
				state_d = S_ARITH;
			end
			S_EL_TRD: begin
				ram_raddr = cell_addr(k_q, j_q);
				state_d   = S_EL_WR;
			end
			S_EL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(k_q, j_q);
				ram_wdata = sat_sub(ram_rdata, arith_res);
				if (j_q == RHS_COL) begin
					if (IW'(k_q + 1'b1) == n_q) begin
						i_d     = IW'(i_q + 1'b1);
						j_d     = '0;
						m_d     = '0;
						best_d  = '0;
						p_d     = '0;
						state_d = S_PIV_RD;
					end else begin
						k_d     = IW'(k_q + 1'b1);
						state_d = S_ELF_RD;
					end
				end else begin
					j_d     = j_next;
					state_d = S_EL_RD;
				end
			end

			// Back substitution: find the unit entry of row i
			S_BK_RD: begin
				ram_raddr = cell_addr(i_q, j_q);
				state_d   = S_BK_CHK;
			end
			S_BK_CHK: begin
				if (mag(sat_sub(ram_rdata, ONE)) < 64'(thr_q))
					m_d = j_q;
				if (j_q == n_q - 1'b1) begin
					state_d = S_BK_XRD;
				end else begin
					j_d     = IW'(j_q + 1'b1);
					state_d = S_BK_RD;
				end
			end
			S_BK_XRD: begin
				ram_raddr = cell_addr(i_q, MAX_SIZE);
				state_d   = S_BK_XGET;
			end
			S_BK_XGET: begin
				t_d     = ram_rdata;
				state_d = S_BK_EMIT;
			end
			S_BK_EMIT: begin
				if (out_free) begin
					emit_bk = 1'b1;
					if (i_q == '0) begin
						state_d = S_IDLE;
					end else begin
						k_d     = '0;
						state_d = S_BK_F_RD;
					end
				end
			end
			S_BK_F_RD: begin
				ram_raddr = cell_addr(k_q, m_q);
				state_d   = S_BK_F_GO;
			end
			S_BK_F_GO: begin
				mul_go    = 1'b1;
				op_a      = ram_rdata;
				op_b      = t_q;
				ram_we    = 1'b1;
				ram_waddr = cell_addr(k_q, m_q);
				ram_wdata = '0;
				ret_d     = S_BK_B_RD;
				state_d   = S_ARITH;
			end
			S_BK_B_RD: begin
				ram_raddr = cell_addr(k_q, MAX_SIZE);
				state_d   = S_BK_WR;
			end
			S_BK_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(k_q, MAX_SIZE);
				ram_wdata = sat_sub(ram_rdata, arith_res);
				if (IW'(k_q + 1'b1) == i_q) begin
					i_d     = IW'(i_q - 1'b1);
					j_d     = '0;
					m_d     = '0;
					state_d = S_BK_RD;
				end else begin
					k_d     = IW'(k_q + 1'b1);
					state_d = S_BK_F_RD;
				end
			end

			// Singular pivot: single error result
			S_ERR: begin
				if (out_free) begin
					emit_err = 1'b1;
					state_d  = S_IDLE;
				end
			end

			// Shared unit busy; return when done
			S_ARITH: begin
				if (arith_done)
					state_d = ret_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/lsg_checker.sv
// Port-level checks for the solver, bound to the top level.
`default_nettype none

module lsg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [lsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [lsg_pkg::CMD_W-1:0]       s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic [0:0]                      m_axis_tuser
);

	import lsg_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Singular result ends the solve with a zero payload
	a_sing_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("singular result malformed");

	// A solve transfer makes the block busy
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SOLVE |=> !s_axis_tready)
		else $error("input ready right after solve transfer");

	// Pad bits above the solution stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[71:68] == 4'b0)
		else $error("result pad bits set");

endmodule

bind linear_system_solver_gauss lsg_checker u_lsg_checker (.*);

`default_nettype wire
